@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the top RTL file of the keyword classifier core.
// No dependencies; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/slkc_pkg.sv @@
// Shared types, keyword tables and constants of the serial line keyword classifier.
// No dependencies; imported by every module of the core.
`default_nettype none

package slkc_pkg;

  localparam int unsigned LINE_BYTES_DEF = 32;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned LEN_W          = 5;

  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_NULL = 8'h00;

  localparam int unsigned KW_PONG_LEN  = 4;
  localparam int unsigned KW_READY_LEN = 8;
  localparam int unsigned KW_UI_LEN    = 3;
  localparam int unsigned KW_ERR_LEN   = 6;

  localparam logic [7:0] KW_PONG  [KW_PONG_LEN]  = '{8'h50, 8'h4F, 8'h4E, 8'h47};
  localparam logic [7:0] KW_READY [KW_READY_LEN] =
    '{8'h48, 8'h37, 8'h5F, 8'h52, 8'h45, 8'h41, 8'h44, 8'h59};
  localparam logic [7:0] KW_UI    [KW_UI_LEN]    = '{8'h55, 8'h49, 8'h20};
  localparam logic [7:0] KW_ERR   [KW_ERR_LEN]   =
    '{8'h48, 8'h37, 8'h5F, 8'h45, 8'h52, 8'h52};

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_READY = 2'd1,
    KIND_UI    = 2'd2,
    KIND_ERR   = 2'd3
  } line_kind_t;

  // One finished line as seen by the back end.
  typedef struct packed {
    logic             hit_ready;
    logic             hit_ui;
    logic             hit_err;
    logic [LEN_W-1:0] len;
  } line_evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/slkc_front.sv @@
// Front end: takes received bytes, tracks line length and keyword matches as they arrive.
// Depends on slkc_pkg; emits one line event per line feed.
`default_nettype none

module slkc_front import slkc_pkg::*; #(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] rx_byte,
  output logic            evt_valid,
  output line_evt_t       evt
);

  localparam int unsigned CW       = $clog2(LINE_BYTES);
  localparam int unsigned HOLD_MAX = LINE_BYTES - 1;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic pong_ok_r, pong_ok_nxt, rdy_ok_r, rdy_ok_nxt;
  logic ui_ok_r, ui_ok_nxt, err_ok_r, err_ok_nxt;
  logic pong_z_r, pong_z_nxt, rdy_z_r, rdy_z_nxt, err_z_r, err_z_nxt;

  logic is_cr, is_lf, first;
  logic eq_pong, eq_rdy, bg_ui, eq_err;
  logic [CW+LEN_W-1:0] cnt_ext;

  assign is_cr = (rx_byte == BYTE_CR);
  assign is_lf = (rx_byte == BYTE_LF);
  assign first = (cnt_r == '0);

  always_comb begin
    cnt_nxt     = cnt_r;
    pong_ok_nxt = pong_ok_r;
    rdy_ok_nxt  = rdy_ok_r;
    ui_ok_nxt   = ui_ok_r;
    err_ok_nxt  = err_ok_r;
    pong_z_nxt  = pong_z_r;
    rdy_z_nxt   = rdy_z_r;
    err_z_nxt   = err_z_r;
    if (acc && is_lf) begin
      cnt_nxt = '0;
    end else if (acc && !is_cr) begin
      if (cnt_r != CW'(HOLD_MAX)) begin
        cnt_nxt = cnt_r + 1'b1;
        // Prefix flags restart on the first byte of a line.
        if (cnt_r < CW'(KW_PONG_LEN)) begin
          pong_ok_nxt = (first || pong_ok_r) && (rx_byte == KW_PONG[cnt_r[1:0]]);
        end else if (cnt_r == CW'(KW_PONG_LEN)) begin
          pong_z_nxt = (rx_byte == BYTE_NULL);
        end
        if (cnt_r < CW'(KW_READY_LEN)) begin
          rdy_ok_nxt = (first || rdy_ok_r) && (rx_byte == KW_READY[cnt_r[2:0]]);
        end else if (cnt_r == CW'(KW_READY_LEN)) begin
          rdy_z_nxt = (rx_byte == BYTE_NULL);
        end
        if (cnt_r < CW'(KW_UI_LEN)) begin
          ui_ok_nxt = (first || ui_ok_r) && (rx_byte == KW_UI[cnt_r[1:0]]);
        end
        if (cnt_r < CW'(KW_ERR_LEN)) begin
          err_ok_nxt = (first || err_ok_r) && (rx_byte == KW_ERR[cnt_r[2:0]]);
        end else if (cnt_r == CW'(KW_ERR_LEN)) begin
          err_z_nxt = (rx_byte == BYTE_NULL);
        end
      end else begin
        // Line overflow: drop the line and this byte.
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    pong_ok_r <= pong_ok_nxt;
    rdy_ok_r  <= rdy_ok_nxt;
    ui_ok_r   <= ui_ok_nxt;
    err_ok_r  <= err_ok_nxt;
    pong_z_r  <= pong_z_nxt;
    rdy_z_r   <= rdy_z_nxt;
    err_z_r   <= err_z_nxt;
  end

  assign eq_pong = (cnt_r >= CW'(KW_PONG_LEN)) && pong_ok_r &&
                   ((cnt_r == CW'(KW_PONG_LEN)) || pong_z_r);
  assign eq_rdy  = (cnt_r >= CW'(KW_READY_LEN)) && rdy_ok_r &&
                   ((cnt_r == CW'(KW_READY_LEN)) || rdy_z_r);
  assign bg_ui   = (cnt_r >= CW'(KW_UI_LEN)) && ui_ok_r;
  assign eq_err  = (cnt_r >= CW'(KW_ERR_LEN)) && err_ok_r &&
                   ((cnt_r == CW'(KW_ERR_LEN)) || err_z_r);

  assign cnt_ext = {{LEN_W{1'b0}}, cnt_r};

  assign evt_valid     = acc && is_lf;
  assign evt.hit_ready = eq_pong || eq_rdy;
  assign evt.hit_ui    = bg_ui;
  assign evt.hit_err   = eq_err;
  assign evt.len       = (cnt_ext > (CW+LEN_W)'(31)) ? LEN_W'(31) : cnt_ext[LEN_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/slkc_queue.sv @@
// Short event queue between front and back end.
// Depends on slkc_pkg for the line event and status types.
`default_nettype none

module slkc_queue import slkc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_en,
  input  wire line_evt_t wr_data,
  input  wire logic      rd_en,
  output line_evt_t      rd_data,
  output queue_stat_t    stat
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  line_evt_t     slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          do_wr, do_rd;

  assign stat.full  = (n_r == NW'(QUEUE_DEPTH));
  assign stat.empty = (n_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = slot_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    n_nxt  = n_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      n_nxt = n_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      n_nxt = n_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      n_r  <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      n_r  <= n_nxt;
    end
    if (do_wr) begin
      slot_r[wp_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/slkc_back.sv @@
// Back end: applies line events to the online flag and holds the result beat.
// Depends on slkc_pkg for the event and line kind types.
`default_nettype none

module slkc_back import slkc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         evt_avail,
  input  wire line_evt_t    evt,
  output logic              evt_take,
  input  wire logic         pop,
  output logic              empty,
  output logic [1:0]        line_kind,
  output logic              online,
  output logic [LEN_W-1:0]  line_length
);

  logic             vld_r, vld_nxt;
  logic             onl_r, onl_nxt;
  line_kind_t       kind_r, kind_nxt;
  logic [LEN_W-1:0] len_r;

  // Reload the output beat whenever it is free or being taken.
  assign evt_take = evt_avail && (!vld_r || pop);

  always_comb begin
    onl_nxt  = onl_r;
    kind_nxt = KIND_OTHER;
    vld_nxt  = vld_r && !pop;
    if (evt.hit_ready) begin
      kind_nxt = KIND_READY;
      onl_nxt  = 1'b1;
    end else if (evt.hit_ui) begin
      kind_nxt = KIND_UI;
      onl_nxt  = 1'b1;
    end else if (evt.hit_err) begin
      kind_nxt = KIND_ERR;
      onl_nxt  = 1'b0;
    end
    if (!evt_take) begin
      onl_nxt  = onl_r;
      kind_nxt = kind_r;
    end else begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      onl_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      onl_r <= onl_nxt;
    end
    kind_r <= kind_nxt;
    if (evt_take) begin
      len_r <= evt.len;
    end
  end

  assign empty       = !vld_r;
  assign line_kind   = kind_r;
  assign online      = onl_r;
  assign line_length = len_r;

endmodule

`default_nettype wire

@@ rtl/core/serial_line_keyword_classifier_core.sv @@
// Serial line keyword classifier: one byte per cycle in, one result beat per line feed.
// A line feed's event is written into the queue, then loaded into the output register.
// Throughput: one byte per cycle unless full, set by the front's keyword flag update.
// A two-entry event queue and the output register let either side stall on its own.
// Reset (synchronous, rst_n low): line empty, link offline, queue and output empty.
// Depends on slkc_pkg, slkc_front, slkc_queue, slkc_back and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module serial_line_keyword_classifier_core import slkc_pkg::*; #(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [7:0]       in_rx_byte,
  output logic                  empty,
  input  wire logic             pop,
  output logic [1:0]            out_line_kind,
  output logic                  out_online,
  output logic [LEN_W-1:0]      out_line_length
);

  logic        acc, evt_valid, evt_take;
  line_evt_t   evt_in, evt_out;
  queue_stat_t q_stat;

  assign full = q_stat.full;
  assign acc  = push && !q_stat.full;

  slkc_front #(.LINE_BYTES(LINE_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .rx_byte   (in_rx_byte),
    .evt_valid (evt_valid),
    .evt       (evt_in)
  );

  slkc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (evt_valid),
    .wr_data (evt_in),
    .rd_en   (evt_take),
    .rd_data (evt_out),
    .stat    (q_stat)
  );

  slkc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt_avail   (!q_stat.empty),
    .evt         (evt_out),
    .evt_take    (evt_take),
    .pop         (pop),
    .empty       (empty),
    .line_kind   (out_line_kind),
    .online      (out_online),
    .line_length (out_line_length)
  );

  `ASSERT_IMPL(a_no_overflow, q_stat.full, !evt_valid, "event pushed into a full queue")
  `ASSERT_NEXT(a_reload, (!empty && pop && !q_stat.empty), !empty, "output beat not reloaded")
  `ASSERT_IMPL(a_err_offline, (!empty && out_line_kind == KIND_ERR), !out_online,
               "error line left the link online")
  `ASSERT_IMPL(a_hit_online, (!empty && (out_line_kind == KIND_READY ||
               out_line_kind == KIND_UI)), out_online, "ready or UI line left link offline")

endmodule

`default_nettype wire
